>>> rtl/lst_pkg.sv
// shared types and constants for the latency statistics table
// no dependencies; imported by every module of the block
`default_nettype none

package lst_pkg;

    localparam int NUM_LEVELS = 16;
    localparam int LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int DATA_W     = 32;

    localparam logic [DATA_W-1:0] MAX_SAMPLE_RESET = 32'd1000000;

    // operation codes
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_LEVEL = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        level;
        logic [DATA_W-1:0] sample_cycles;
    } lst_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] count_out;
        logic [DATA_W-1:0] sum_out;
        logic [DATA_W-1:0] min_out;
        logic [DATA_W-1:0] max_out;
    } lst_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } lst_cmd_t;

endpackage

`default_nettype wire

>>> rtl/lst_ctrl.sv
// controller for the latency statistics table: accept and execute sequencing
// depends on lst_pkg
`default_nettype none

module lst_ctrl
    import lst_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output lst_cmd_t      dp_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   exec_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            exec_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            exec_reg  <= (state_next == S_EXEC);
        end
    end

    assign busy        = busy_reg;
    assign dp_cmd.load = accept;
    assign dp_cmd.exec = exec_reg;

endmodule

`default_nettype wire

>>> rtl/lst_datapath.sv
// datapath for the latency statistics table: item latch, level table,
// limit register and result register; depends on lst_pkg
`default_nettype none

module lst_datapath
    import lst_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lst_cmd_t          dp_cmd,
    input  wire lst_in_t           cmd,
    input  wire logic              cfg_we,
    input  wire logic [DATA_W-1:0] cfg_wdata,
    output logic                   done,
    output lst_out_t               result
);

    lst_in_t           item_reg;
    logic [DATA_W-1:0] limit_reg;

    logic [DATA_W-1:0] count_reg [NUM_LEVELS];
    logic [DATA_W-1:0] sum_reg   [NUM_LEVELS];
    logic [DATA_W-1:0] min_reg   [NUM_LEVELS];
    logic [DATA_W-1:0] max_reg   [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] valid_reg;

    lst_out_t result_reg;
    lst_out_t result_next;
    logic     done_reg;

    logic [LVL_W-1:0]  idx;
    logic              level_ok;
    logic              sample_ok;
    logic [DATA_W-1:0] cur_count;
    logic [DATA_W-1:0] cur_sum;
    logic [DATA_W-1:0] cur_min;
    logic [DATA_W-1:0] cur_max;
    logic [DATA_W-1:0] new_min;
    logic [DATA_W-1:0] new_max;
    logic              do_write;
    logic              do_clear;

    assign idx      = item_reg.level[LVL_W-1:0];
    assign level_ok = ({1'b0, item_reg.level} < 9'(NUM_LEVELS));
    assign sample_ok = (item_reg.sample_cycles != '0)
                       && (item_reg.sample_cycles <= limit_reg);

    // an entry never written since the last clear reads as zero
    always_comb
    begin
        if (valid_reg[idx])
        begin
            cur_count = count_reg[idx];
            cur_sum   = sum_reg[idx];
            cur_min   = min_reg[idx];
            cur_max   = max_reg[idx];
        end
        else
        begin
            cur_count = '0;
            cur_sum   = '0;
            cur_min   = '0;
            cur_max   = '0;
        end
    end

    // a min of zero marks an empty level
    assign new_min = ((cur_min == '0) || (item_reg.sample_cycles < cur_min))
                     ? item_reg.sample_cycles : cur_min;
    assign new_max = (item_reg.sample_cycles > cur_max)
                     ? item_reg.sample_cycles : cur_max;

    always_comb
    begin
        result_next = '0;
        do_write    = 1'b0;
        do_clear    = 1'b0;
        case (item_reg.operation)
            OP_RECORD:
            begin
                if (!level_ok)
                begin
                    result_next.status = ST_BAD_LEVEL;
                end
                else if (!sample_ok)
                begin
                    result_next.status = ST_REJECTED;
                end
                else
                begin
                    result_next.status = ST_DONE;
                    do_write           = 1'b1;
                end
            end
            OP_READ:
            begin
                if (!level_ok)
                begin
                    result_next.status = ST_BAD_LEVEL;
                end
                else
                begin
                    result_next.status    = ST_DONE;
                    result_next.count_out = cur_count;
                    result_next.sum_out   = cur_sum;
                    result_next.min_out   = cur_min;
                    result_next.max_out   = cur_max;
                end
            end
            OP_CLEAR:
            begin
                result_next.status = ST_DONE;
                do_clear           = 1'b1;
            end
            default:
            begin
                result_next.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            item_reg <= cmd;
        end
        if (dp_cmd.exec)
        begin
            result_reg <= result_next;
        end
        if (dp_cmd.exec && do_write)
        begin
            count_reg[idx] <= cur_count + 1'b1;
            sum_reg[idx]   <= cur_sum + item_reg.sample_cycles;
            min_reg[idx]   <= new_min;
            max_reg[idx]   <= new_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= MAX_SAMPLE_RESET;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= dp_cmd.exec;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (dp_cmd.exec && do_clear)
            begin
                valid_reg <= '0;
            end
            else if (dp_cmd.exec && do_write)
            begin
                valid_reg[idx] <= 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/latency_stats_table.sv
// top level of the latency statistics table: controller plus datapath
// depends on lst_pkg, lst_ctrl, lst_datapath
//
//   port group            dir  handshake          payload
//   start/busy/cmd        in   start & !busy      lst_in_t
//   done/result           out  done strobe        lst_out_t
//   cfg_we/cfg_wdata      in   cfg_we             max sample cycles limit
//
// the accept edge latches an item; in the next cycle the block reads the level's
// entry, updates it and loads the result register.
// done is high for one cycle, starting at the edge on which busy falls; a new item
// may be accepted on the same edge that takes the result.
// reset clears the table through per-level valid bits; a clear item does the
// same. the receiver cannot stall.
`default_nettype none

module latency_stats_table
    import lst_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire lst_in_t           cmd,
    output logic                   done,
    output lst_out_t               result,
    input  wire logic              cfg_we,
    input  wire logic [DATA_W-1:0] cfg_wdata
);

    lst_cmd_t dp_cmd;

    lst_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .dp_cmd (dp_cmd)
    );

    lst_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> test/tb.sv
// testbench for latency_stats_table: records, reads and clears with random gaps,
// checked item by item against a table kept alongside the block
// depends on lst_pkg and the rtl of latency_stats_table
module tb;
    import lst_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 12;

    typedef struct {
        bit                limit_write;
        logic [DATA_W-1:0] limit;
        lst_in_t           item;
    } table_job_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    lst_in_t           cmd = '0;
    logic              done;
    lst_out_t          result;
    logic              cfg_we = 1'b0;
    logic [DATA_W-1:0] cfg_wdata = '0;

    // shadow of the statistics table
    logic [DATA_W-1:0] lvl_count [NUM_LEVELS];
    logic [DATA_W-1:0] lvl_sum [NUM_LEVELS];
    logic [DATA_W-1:0] lvl_min [NUM_LEVELS];
    logic [DATA_W-1:0] lvl_max [NUM_LEVELS];
    logic [DATA_W-1:0] cycle_limit = MAX_SAMPLE_RESET;

    table_job_t        pending_jobs[$];
    lst_out_t          expected_stats[$];
    logic [DATA_W-1:0] planned_limit = MAX_SAMPLE_RESET;

    int                error_count = 0;
    int                stall_cycles = 0;
    int                gap_left;
    int                quiet_cycles;
    logic              nxt_start;
    lst_in_t           nxt_cmd;
    logic              nxt_we;
    logic [DATA_W-1:0] nxt_wdata;
    lst_out_t          seen_want;

    latency_stats_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void wipe_table();
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            lvl_count[i] = '0;
            lvl_sum[i]   = '0;
            lvl_min[i]   = '0;
            lvl_max[i]   = '0;
        end
    endfunction

    function automatic lst_out_t apply_to_table(lst_in_t c);
        lst_out_t         r;
        logic [LVL_W-1:0] idx;
        r = '0;
        r.status = ST_DONE;
        idx = c.level[LVL_W-1:0];
        case (c.operation)
            OP_RECORD:
            begin
                if (c.level >= NUM_LEVELS)
                    r.status = ST_BAD_LEVEL;
                else if (c.sample_cycles == '0 || c.sample_cycles > cycle_limit)
                    r.status = ST_REJECTED;
                else
                begin
                    lvl_count[idx] = lvl_count[idx] + 1;
                    lvl_sum[idx]   = lvl_sum[idx] + c.sample_cycles;
                    // a zero minimum marks an empty level
                    if (lvl_min[idx] == '0 || c.sample_cycles < lvl_min[idx])
                        lvl_min[idx] = c.sample_cycles;
                    if (c.sample_cycles > lvl_max[idx])
                        lvl_max[idx] = c.sample_cycles;
                end
            end
            OP_READ:
            begin
                if (c.level >= NUM_LEVELS)
                    r.status = ST_BAD_LEVEL;
                else
                begin
                    r.count_out = lvl_count[idx];
                    r.sum_out   = lvl_sum[idx];
                    r.min_out   = lvl_min[idx];
                    r.max_out   = lvl_max[idx];
                end
            end
            OP_CLEAR:
                wipe_table();
            default:
                r.status = ST_DONE;
        endcase
        return r;
    endfunction

    function automatic void queue_item(logic [1:0] op, logic [7:0] lvl, logic [DATA_W-1:0] cyc);
        table_job_t j;
        j.limit_write = 1'b0;
        j.limit = '0;
        j.item.operation = op;
        j.item.level = lvl;
        j.item.sample_cycles = cyc;
        pending_jobs.push_back(j);
    endfunction

    function automatic void queue_limit(logic [DATA_W-1:0] value);
        table_job_t j;
        j.limit_write = 1'b1;
        j.limit = value;
        j.item = '0;
        pending_jobs.push_back(j);
        planned_limit = value;
    endfunction

    // samples cluster around the limit that will be in force
    function automatic logic [DATA_W-1:0] pick_sample();
        logic [DATA_W-1:0] lim;
        lim = planned_limit;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return lim;
            2:       return lim + 1;
            3, 4:    return $urandom();
            5:       return $urandom_range(16, 1);
            default: return (lim == '0) ? $urandom() : $urandom_range(lim, 1);
        endcase
    endfunction

    function automatic void queue_random_item();
        int         r;
        logic [1:0] op;
        logic [7:0] lvl;
        r = $urandom_range(0, 99);
        if (r < 57)
            op = OP_RECORD;
        else if (r < 97)
            op = OP_READ;
        else if (r < 98)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        if ($urandom_range(0, 7) == 0)
            lvl = 8'($urandom_range(255, 0));
        else
            lvl = 8'($urandom_range(NUM_LEVELS - 1, 0));
        queue_item(op, lvl, pick_sample());
    endfunction

    // mostly back to back or short, now and then a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // driver: issues items and limit writes from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            cfg_we <= 1'b0;
            cfg_wdata <= '0;
            gap_left = 0;
            quiet_cycles = 0;
            cycle_limit = MAX_SAMPLE_RESET;
            wipe_table();
        end
        else
        begin
            nxt_start = start;
            nxt_cmd = cmd;
            nxt_we = 1'b0;
            nxt_wdata = cfg_wdata;
            if (start && !busy)
            begin
                expected_stats.push_back(apply_to_table(cmd));
                nxt_start = 1'b0;
                gap_left = pick_gap();
            end
            if (start || cfg_we || expected_stats.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (!nxt_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_jobs.size() != 0)
                begin
                    if (!pending_jobs[0].limit_write)
                    begin
                        nxt_start = 1'b1;
                        nxt_cmd = pending_jobs[0].item;
                        void'(pending_jobs.pop_front());
                    end
                    else if (quiet_cycles >= SETTLE_CYCLES)
                    begin
                        // table is idle, safe to move the limit
                        nxt_we = 1'b1;
                        nxt_wdata = pending_jobs[0].limit;
                        cycle_limit = pending_jobs[0].limit;
                        void'(pending_jobs.pop_front());
                        quiet_cycles = 0;
                    end
                end
            end
            start <= nxt_start;
            cmd <= nxt_cmd;
            cfg_we <= nxt_we;
            cfg_wdata <= nxt_wdata;
        end
    end

    // monitor: every strobed result is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (expected_stats.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %p", $time, result);
                error_count++;
            end
            else
            begin
                seen_want = expected_stats.pop_front();
                check_field("status", DATA_W'(seen_want.status), DATA_W'(result.status));
                check_field("count_out", seen_want.count_out, result.count_out);
                check_field("sum_out", seen_want.sum_out, result.sum_out);
                check_field("min_out", seen_want.min_out, result.min_out);
                check_field("max_out", seen_want.max_out, result.max_out);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [DATA_W-1:0] phase_limit [7];
        int                phase_items [7];

        // empty table, limit edges, bad levels, unused code, clear
        queue_item(OP_READ, 8'd0, '0);
        queue_item(OP_RECORD, 8'd0, 32'd1);
        queue_item(OP_RECORD, 8'd0, MAX_SAMPLE_RESET);
        queue_item(OP_RECORD, 8'd0, MAX_SAMPLE_RESET + 1);
        queue_item(OP_RECORD, 8'd0, '0);
        queue_item(OP_RECORD, 8'd15, 32'hFFFF_FFFF);
        queue_item(OP_RECORD, 8'd16, 32'd5);
        queue_item(OP_RECORD, 8'd255, '0);
        queue_item(OP_READ, 8'd0, 32'hFFFF_FFFF);
        queue_item(OP_READ, 8'd15, '0);
        queue_item(OP_READ, 8'd16, '0);
        queue_item(OP_READ, 8'd255, 32'h1234_5678);
        queue_item(OP_UNUSED, 8'hAA, 32'h5555_5555);
        queue_item(OP_CLEAR, 8'd255, 32'hFFFF_FFFF);
        queue_item(OP_READ, 8'd0, '0);
        // widest limit, sum wraps
        queue_limit(32'hFFFF_FFFF);
        queue_item(OP_RECORD, 8'd3, 32'hFFFF_FFFF);
        queue_item(OP_RECORD, 8'd3, 32'hFFFF_FFFF);
        queue_item(OP_RECORD, 8'd3, 32'd1);
        queue_item(OP_READ, 8'd3, '0);
        // zero limit rejects everything
        queue_limit('0);
        queue_item(OP_RECORD, 8'd2, 32'd1);
        queue_limit(32'd1);
        queue_item(OP_RECORD, 8'd2, 32'd1);
        queue_item(OP_RECORD, 8'd2, 32'd2);
        queue_item(OP_READ, 8'd2, '0);

        phase_limit = '{MAX_SAMPLE_RESET, 32'd100, 32'hFFFF_FFFF, $urandom(),
                        32'd1, 32'd0, 32'd5000};
        phase_items = '{300, 300, 300, 300, 200, 100, 300};
        for (int p = 0; p < 7; p++)
        begin
            queue_limit(phase_limit[p]);
            for (int n = 0; n < phase_items[p]; n++)
                queue_random_item();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_jobs.size() != 0 || start || expected_stats.size() != 0)
               && stall_cycles < STALL_LIMIT)
            @(posedge clk);

        if (stall_cycles >= STALL_LIMIT)
            $display("tb: errors");
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (error_count == 0 && expected_stats.size() == 0)
                $display("tb: clean");
            else
                $display("tb: errors");
        end
        $finish;
    end

endmodule
